### hw/rtl/stg_pkg.sv
// Shared types and constants of the trapezoid step generator.
`timescale 1ns / 1ps
`default_nettype none
package stg_pkg;

    localparam int AXES       = 4;
    localparam int COUNT_BITS = 24;
    localparam int ERR_BITS   = 26;
    localparam int RATE_BITS  = 20;
    localparam int PEAK_BITS  = 28;
    localparam int ACC_BITS   = 24;
    localparam int TICK_BITS  = 32;
    localparam int PROD_BITS  = 48;
    localparam int DIV_BITS   = 28;
    localparam int DCNT_BITS  = 5;

    localparam logic [DIV_BITS-1:0]  CLOCK_HZ = 28'd200000000;
    localparam logic [RATE_BITS-1:0] RATE_MAX = 20'hFFFFF;
    localparam logic [PEAK_BITS-1:0] PEAK_MAX = 28'hFFFFFFF;

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_STEP = 1'b1;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_MUL  = 5'b00010,
        ST_VSEL = 5'b00100,
        ST_DIV  = 5'b01000,
        ST_FIN  = 5'b10000
    } state_t;

endpackage
`default_nettype wire

### hw/rtl/stepper_trapezoid_step_generator_unit.sv
// Top level: four-axis Bresenham step generator with trapezoid speed ramp.
`timescale 1ns / 1ps
`default_nettype none
// A load item (tuser = 0) latches a move when accepted and then runs a radix-2
// divider that forms the peak rate as clock / cruise interval. A step item
// (tuser = 1) yields one step command. A cruise step goes from accept straight
// to output. A ramp step passes through accept, a multiply state, a rate select
// state, the shared restoring divider (clock / rate) and the output state.
// The output state waits while the previous result still sits unaccepted in
// the output register. A step with no active move gives no result. Input is
// taken whenever the sequencer is idle, even while a result still waits in the
// output register.
module stepper_trapezoid_step_generator_unit (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // count_x, count_y, count_z, count_e, dir_bits, start_rate, end_rate,
    // accel_factor, cruise_interval, ramp_up_steps, ramp_down_steps, zero pad
    input  wire logic [247:0] s_tdata,
    // kind
    input  wire logic [0:0]   s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // step_mask, dir_mask, step_delay
    output logic [39:0]       m_tdata,
    output logic              m_tlast
);

    stg_pkg::state_t state_reg, state_next;

    logic [stg_pkg::COUNT_BITS-1:0] cnt_reg [stg_pkg::AXES];
    logic [stg_pkg::COUNT_BITS-1:0] cnt_next [stg_pkg::AXES];
    logic [stg_pkg::ERR_BITS-1:0]   err_reg [stg_pkg::AXES];
    logic [stg_pkg::ERR_BITS-1:0]   err_next [stg_pkg::AXES];
    logic [stg_pkg::COUNT_BITS-1:0] prim_reg, prim_next, idx_reg, idx_next;
    logic [stg_pkg::COUNT_BITS-1:0] up_reg, up_next, down_reg, down_next;
    logic [stg_pkg::TICK_BITS-1:0]  timer_reg, timer_next, cruise_reg, cruise_next;
    logic [stg_pkg::RATE_BITS-1:0]  reached_reg, reached_next;
    logic [stg_pkg::RATE_BITS-1:0]  start_reg, start_next, end_reg, end_next;
    logic [stg_pkg::PEAK_BITS-1:0]  peak_reg, peak_next;
    logic [stg_pkg::ACC_BITS-1:0]   accel_reg, accel_next;
    logic [3:0]                     dirs_reg, dirs_next, mask_reg, mask_next;
    logic                           active_reg, active_next, decel_reg, decel_next;
    logic                           load_op_reg, load_op_next, up_ph_reg, up_ph_next;
    logic [stg_pkg::PROD_BITS-1:0]  prod_reg, prod_next;
    logic [stg_pkg::TICK_BITS-1:0]  den_reg, den_next;
    logic [stg_pkg::TICK_BITS:0]    rem_reg, rem_next;
    logic [stg_pkg::DIV_BITS-1:0]   quo_reg, quo_next;
    logic [stg_pkg::DCNT_BITS-1:0]  dcnt_reg, dcnt_next;
    logic [stg_pkg::TICK_BITS-1:0]  delay_reg, delay_next;
    logic                           mv_reg, mv_next, ml_reg, ml_next;
    logic [39:0]                    md_reg, md_next;

    logic                           s_fire, out_free;
    logic [stg_pkg::COUNT_BITS-1:0] in_cnt [stg_pkg::AXES];
    logic [stg_pkg::COUNT_BITS-1:0] maxc;
    logic [stg_pkg::ERR_BITS-1:0]   e_sub;
    logic [stg_pkg::TICK_BITS:0]    trial;
    logic [37:0]                    rft;
    logic [38:0]                    vsum;
    logic [stg_pkg::PEAK_BITS-1:0]  v_up;
    logic [stg_pkg::RATE_BITS-1:0]  v_dn, diff;
    logic [stg_pkg::TICK_BITS:0]    tsum;
    logic                           last;

    assign s_tready = (state_reg == stg_pkg::ST_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign out_free = !mv_reg || m_tready;
    assign m_tvalid = mv_reg;
    assign m_tdata  = md_reg;
    assign m_tlast  = ml_reg;

    assign in_cnt[0] = s_tdata[23:0];
    assign in_cnt[1] = s_tdata[47:24];
    assign in_cnt[2] = s_tdata[71:48];
    assign in_cnt[3] = s_tdata[95:72];

    always_comb begin
        maxc = '0;
        for (int i = 0; i < stg_pkg::AXES; i++) begin
            if (in_cnt[i] > maxc) begin
                maxc = in_cnt[i];
            end
        end
    end

    // ramp rate from timer, and candidate rates for both ramps
    assign rft  = prod_reg[stg_pkg::PROD_BITS-1:10];
    assign vsum = {1'b0, rft} + {19'd0, start_reg};
    assign v_up = (vsum > {11'd0, peak_reg}) ? peak_reg : vsum[stg_pkg::PEAK_BITS-1:0];
    assign diff = reached_reg - rft[stg_pkg::RATE_BITS-1:0];
    always_comb begin
        if (rft > {18'd0, reached_reg}) begin
            v_dn = end_reg;
        end else if (diff < end_reg) begin
            v_dn = end_reg;
        end else begin
            v_dn = diff;
        end
    end

    assign trial = {rem_reg[stg_pkg::TICK_BITS-1:0],
                    stg_pkg::CLOCK_HZ[stg_pkg::DCNT_BITS'(stg_pkg::DIV_BITS-1) - dcnt_reg]};
    assign tsum  = {1'b0, timer_reg} + {5'd0, quo_next};
    assign last  = ({1'b0, idx_reg} + 25'd1) >= {1'b0, prim_reg};

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        err_next     = err_reg;
        prim_next    = prim_reg;
        idx_next     = idx_reg;
        up_next      = up_reg;
        down_next    = down_reg;
        timer_next   = timer_reg;
        cruise_next  = cruise_reg;
        reached_next = reached_reg;
        start_next   = start_reg;
        end_next     = end_reg;
        peak_next    = peak_reg;
        accel_next   = accel_reg;
        dirs_next    = dirs_reg;
        mask_next    = mask_reg;
        active_next  = active_reg;
        decel_next   = decel_reg;
        load_op_next = load_op_reg;
        up_ph_next   = up_ph_reg;
        prod_next    = prod_reg;
        den_next     = den_reg;
        rem_next     = rem_reg;
        quo_next     = quo_reg;
        dcnt_next    = dcnt_reg;
        delay_next   = delay_reg;
        mv_next      = mv_reg && !m_tready;
        ml_next      = ml_reg;
        md_next      = md_reg;
        e_sub        = '0;

        unique case (state_reg)
            stg_pkg::ST_IDLE: begin
                if (s_fire && s_tuser[0] == stg_pkg::KIND_LOAD) begin
                    for (int i = 0; i < stg_pkg::AXES; i++) begin
                        cnt_next[i] = in_cnt[i];
                        err_next[i] = {2'd0, 1'b0, maxc[stg_pkg::COUNT_BITS-1:1]};
                    end
                    prim_next    = maxc;
                    dirs_next    = s_tdata[99:96];
                    start_next   = s_tdata[119:100];
                    end_next     = s_tdata[139:120];
                    accel_next   = s_tdata[163:140];
                    cruise_next  = s_tdata[195:164];
                    up_next      = s_tdata[219:196];
                    down_next    = s_tdata[243:220];
                    reached_next = s_tdata[119:100];
                    timer_next   = '0;
                    idx_next     = '0;
                    decel_next   = 1'b0;
                    active_next  = (maxc != '0);
                    load_op_next = 1'b1;
                    den_next     = (s_tdata[195:164] == '0) ? 32'd1 : s_tdata[195:164];
                    rem_next     = '0;
                    dcnt_next    = '0;
                    state_next   = stg_pkg::ST_DIV;
                end else if (s_fire && active_reg) begin
                    for (int i = 0; i < stg_pkg::AXES; i++) begin
                        e_sub = err_reg[i] - {2'd0, cnt_reg[i]};
                        mask_next[i] = e_sub[stg_pkg::ERR_BITS-1];
                        err_next[i]  = e_sub[stg_pkg::ERR_BITS-1] ?
                                       e_sub + {2'd0, prim_reg} : e_sub;
                    end
                    load_op_next = 1'b0;
                    if (idx_reg < up_reg) begin
                        up_ph_next = 1'b1;
                        state_next = stg_pkg::ST_MUL;
                    end else if (down_reg >= prim_reg || idx_reg >= prim_reg - down_reg) begin
                        up_ph_next = 1'b0;
                        if (!decel_reg) begin
                            decel_next = 1'b1;
                            timer_next = '0;
                        end
                        state_next = stg_pkg::ST_MUL;
                    end else begin
                        delay_next = cruise_reg;
                        state_next = stg_pkg::ST_FIN;
                    end
                end
            end
            stg_pkg::ST_MUL: begin
                prod_next  = {16'd0, timer_reg[stg_pkg::TICK_BITS-1:8]} *
                             {24'd0, accel_reg};
                state_next = stg_pkg::ST_VSEL;
            end
            stg_pkg::ST_VSEL: begin
                if (up_ph_reg) begin
                    reached_next = (v_up > {8'd0, stg_pkg::RATE_MAX}) ?
                                   stg_pkg::RATE_MAX : v_up[stg_pkg::RATE_BITS-1:0];
                    den_next = (v_up == '0) ? 32'd1 : {4'd0, v_up};
                end else begin
                    den_next = (v_dn == '0) ? 32'd1 : {12'd0, v_dn};
                end
                rem_next   = '0;
                dcnt_next  = '0;
                state_next = stg_pkg::ST_DIV;
            end
            stg_pkg::ST_DIV: begin
                // one quotient bit per cycle, dividend is the clock rate
                if (trial >= {1'b0, den_reg}) begin
                    rem_next = trial - {1'b0, den_reg};
                    quo_next = {quo_reg[stg_pkg::DIV_BITS-2:0], 1'b1};
                end else begin
                    rem_next = trial;
                    quo_next = {quo_reg[stg_pkg::DIV_BITS-2:0], 1'b0};
                end
                dcnt_next = dcnt_reg + 1'b1;
                if (dcnt_reg == stg_pkg::DCNT_BITS'(stg_pkg::DIV_BITS-1)) begin
                    if (load_op_reg) begin
                        peak_next  = quo_next;
                        state_next = stg_pkg::ST_IDLE;
                    end else begin
                        delay_next = {4'd0, quo_next};
                        timer_next = tsum[stg_pkg::TICK_BITS] ? '1 :
                                     tsum[stg_pkg::TICK_BITS-1:0];
                        state_next = stg_pkg::ST_FIN;
                    end
                end
            end
            stg_pkg::ST_FIN: begin
                if (out_free) begin
                    mv_next  = 1'b1;
                    ml_next  = last;
                    md_next  = {delay_reg, dirs_reg, mask_reg};
                    idx_next = idx_reg + 1'b1;
                    if (last) begin
                        active_next = 1'b0;
                    end
                    state_next = stg_pkg::ST_IDLE;
                end
            end
            default: state_next = stg_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= stg_pkg::ST_IDLE;
            for (int i = 0; i < stg_pkg::AXES; i++) begin
                cnt_reg[i] <= '0;
                err_reg[i] <= '0;
            end
            prim_reg    <= '0;
            idx_reg     <= '0;
            up_reg      <= '0;
            down_reg    <= '0;
            timer_reg   <= '0;
            cruise_reg  <= 32'd1;
            reached_reg <= '0;
            start_reg   <= '0;
            end_reg     <= '0;
            peak_reg    <= '0;
            accel_reg   <= '0;
            dirs_reg    <= '0;
            active_reg  <= 1'b0;
            decel_reg   <= 1'b0;
            mv_reg      <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            err_reg     <= err_next;
            prim_reg    <= prim_next;
            idx_reg     <= idx_next;
            up_reg      <= up_next;
            down_reg    <= down_next;
            timer_reg   <= timer_next;
            cruise_reg  <= cruise_next;
            reached_reg <= reached_next;
            start_reg   <= start_next;
            end_reg     <= end_next;
            peak_reg    <= peak_next;
            accel_reg   <= accel_next;
            dirs_reg    <= dirs_next;
            active_reg  <= active_next;
            decel_reg   <= decel_next;
            mv_reg      <= mv_next;
        end
    end

    always_ff @(posedge aclk) begin
        load_op_reg <= load_op_next;
        up_ph_reg   <= up_ph_next;
        mask_reg    <= mask_next;
        prod_reg    <= prod_next;
        den_reg     <= den_next;
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
        dcnt_reg    <= dcnt_next;
        delay_reg   <= delay_next;
        ml_reg      <= ml_next;
        md_reg      <= md_next;
    end

    a_load_divides: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && s_tuser[0] == stg_pkg::KIND_LOAD |=> state_reg == stg_pkg::ST_DIV)
        else $error("load item did not start the divider");

    a_den_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == stg_pkg::ST_DIV |-> den_reg != '0)
        else $error("divider running with zero divisor");

    a_err_nonneg: assert property (@(posedge aclk) disable iff (!aresetn)
        !(err_reg[0][stg_pkg::ERR_BITS-1] || err_reg[1][stg_pkg::ERR_BITS-1] ||
          err_reg[2][stg_pkg::ERR_BITS-1] || err_reg[3][stg_pkg::ERR_BITS-1]))
        else $error("Bresenham error term went negative");

    a_last_ends_move: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == stg_pkg::ST_FIN && out_free && last |=> !active_reg)
        else $error("move still active after its last step");

endmodule
`default_nettype wire
